@@ rtl/cpa_pkg.sv @@
// Shared types, constants and codes for the contiguous page allocator.
// Used by the page flag memory and by the allocator top level.
`default_nettype none

package cpa_pkg;

  // Built store depth and page size.
  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;

  // Field widths fixed by the interface.
  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 13;
  localparam int STAT_W  = 2;

  // Page index width and the width of a page count up to the store depth.
  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int NUM_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;

  // Opcodes of an input request.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_RUN   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_HEAP_BASE    = 1'b0;
  localparam logic CFG_PAGES_IN_USE = 1'b1;

  // Flags kept for each page.
  typedef struct packed {
    logic taken;
    logic last;
  } page_flag_t;

  // Write port of the page flag memory.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    page_flag_t       data;
  } flag_wr_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_ALLOC_MARK,
    ST_FREE_CHECK,
    ST_FREE_WALK,
    ST_RESP
  } cpa_state_t;

endpackage

`default_nettype wire

@@ rtl/cpa_page_flags.sv @@
// Page flag store: one synchronous memory with one write and one read port.
// Depends on cpa_pkg for the depth, the flag type and the write port struct.
`default_nettype none

module cpa_page_flags
  import cpa_pkg::*;
(
  input  wire logic             clk,
  input  wire flag_wr_t         wr,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output page_flag_t            rd_data
);

  page_flag_t mem [MAX_PAGES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/contiguous_page_allocator_unit.sv @@
// First-fit contiguous page allocator with its page flags in one memory.
// Allocate scans for a free run, then marks it; free walks the block's pages.
// One request is worked on at a time; the memory reads one page per cycle,
// which sets the scan and walk lengths. After reset a clearing pass empties
// the flag memory, and no request is taken during it. Depends on cpa_pkg and
// cpa_page_flags.
`default_nettype none

module contiguous_page_allocator_unit
  import cpa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration write channel.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [ADDR_W-1:0]  cfg_data,
  // Request channel.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic [COUNT_W-1:0] page_count,
  input  wire logic [ADDR_W-1:0]  block_address,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ADDR_W-1:0]       result_address,
  output logic [STAT_W-1:0]       status
);

  cpa_state_t state, state_next;

  // Configuration registers.
  logic [ADDR_W-1:0]  heap_base;
  logic [COUNT_W-1:0] pages_in_use;

  // Sequencer registers.
  logic [IDX_W-1:0]   clr_idx, clr_idx_next;
  logic [NUM_W-1:0]   scan_idx, scan_idx_next;
  logic               rd_valid, rd_valid_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [NUM_W-1:0]   run, run_next;
  logic [IDX_W-1:0]   mark_idx, mark_idx_next;
  logic [IDX_W-1:0]   last_idx, last_idx_next;
  logic [COUNT_W-1:0] req_count, req_count_next;
  logic [ADDR_W-1:0]  req_addr, req_addr_next;
  logic [ADDR_W-1:0]  pend_addr, pend_addr_next;
  logic [STAT_W-1:0]  pend_status, pend_status_next;
  logic               out_valid_next;
  logic [ADDR_W-1:0]  result_address_next;
  logic [STAT_W-1:0]  status_next;

  // Memory ports.
  flag_wr_t           wr;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  page_flag_t         rd_data;

  // Working values.
  logic [NUM_W-1:0]   n_pages;
  logic [NUM_W-1:0]   count_ext;
  logic [NUM_W-1:0]   run_cand;
  logic [NUM_W-1:0]   start_idx;
  logic               rd_is_final;
  logic [ADDR_W:0]    heap_end;
  logic [ADDR_W-1:0]  offset;
  logic               free_bad;
  logic               in_accept;

  cpa_page_flags u_flags (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Managed pages: the register saturated at the store depth.
  assign n_pages = (NUM_W'(pages_in_use) > NUM_W'(MAX_PAGES)) ? NUM_W'(MAX_PAGES)
                                                              : NUM_W'(pages_in_use);
  assign count_ext   = NUM_W'(req_count);
  assign run_cand    = rd_data.taken ? '0 : run + NUM_W'(1);
  assign start_idx   = NUM_W'(rd_idx) + NUM_W'(1) - count_ext;
  assign rd_is_final = (NUM_W'(rd_idx) + NUM_W'(1)) == n_pages;

  // Free address checks against the heap span, computed without wrap.
  assign heap_end = {1'b0, heap_base} + ((ADDR_W + 1)'(n_pages) << PAGE_SHIFT);
  assign offset   = req_addr - heap_base;
  assign free_bad = (req_addr == '0) || ({1'b0, req_addr} >= heap_end)
                    || (req_addr < heap_base);

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base    <= '0;
      pages_in_use <= COUNT_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEAP_BASE:    heap_base    <= cfg_data;
        CFG_PAGES_IN_USE: pages_in_use <= cfg_data[COUNT_W-1:0];
        default:          heap_base    <= heap_base;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    scan_idx       <= scan_idx_next;
    rd_idx         <= rd_idx_next;
    run            <= run_next;
    mark_idx       <= mark_idx_next;
    last_idx       <= last_idx_next;
    req_count      <= req_count_next;
    req_addr       <= req_addr_next;
    pend_addr      <= pend_addr_next;
    pend_status    <= pend_status_next;
    result_address <= result_address_next;
    status         <= status_next;
  end

  // Next state, memory accesses and result staging.
  always_comb begin
    state_next          = state;
    clr_idx_next        = clr_idx;
    scan_idx_next       = scan_idx;
    rd_valid_next       = 1'b0;
    rd_idx_next         = rd_idx;
    run_next            = run;
    mark_idx_next       = mark_idx;
    last_idx_next       = last_idx;
    req_count_next      = req_count;
    req_addr_next       = req_addr;
    pend_addr_next      = pend_addr;
    pend_status_next    = pend_status;
    out_valid_next      = out_valid && out_stall;
    result_address_next = result_address;
    status_next         = status;
    wr                  = '0;
    rd_en               = 1'b0;
    rd_addr             = scan_idx[IDX_W-1:0];

    case (state)
      // Clearing pass: one page per cycle after reset.
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_idx;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (clr_idx == IDX_W'(MAX_PAGES - 1)) begin
          state_next = ST_IDLE;
        end
      end

      // Take a request and screen it.
      ST_IDLE: begin
        if (in_accept) begin
          req_count_next = page_count;
          req_addr_next  = block_address;
          scan_idx_next  = '0;
          run_next       = '0;
          pend_addr_next = '0;
          if (opcode == OP_FREE) begin
            state_next = ST_FREE_CHECK;
          end else if ((page_count == '0) || (NUM_W'(page_count) > n_pages)) begin
            pend_status_next = STAT_NO_RUN;
            state_next       = ST_RESP;
          end else begin
            state_next = ST_ALLOC_SCAN;
          end
        end
      end

      // First-fit search: one read per cycle, each read's data checked from the registered read port.
      ST_ALLOC_SCAN: begin
        if (scan_idx < n_pages) begin
          rd_en         = 1'b1;
          rd_valid_next = 1'b1;
          rd_idx_next   = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + NUM_W'(1);
        end
        if (rd_valid) begin
          run_next = run_cand;
          if (run_cand == count_ext) begin
            mark_idx_next    = start_idx[IDX_W-1:0];
            last_idx_next    = rd_idx;
            pend_addr_next   = heap_base + (ADDR_W'(start_idx[IDX_W-1:0]) << PAGE_SHIFT);
            pend_status_next = STAT_OK;
            rd_valid_next    = 1'b0;
            state_next       = ST_ALLOC_MARK;
          end else if (rd_is_final) begin
            pend_status_next = STAT_NO_RUN;
            rd_valid_next    = 1'b0;
            state_next       = ST_RESP;
          end
        end
      end

      // Mark the found run taken, the final page also last.
      ST_ALLOC_MARK: begin
        wr.en         = 1'b1;
        wr.addr       = mark_idx;
        wr.data.taken = 1'b1;
        wr.data.last  = (mark_idx == last_idx);
        mark_idx_next = mark_idx + IDX_W'(1);
        if (mark_idx == last_idx) begin
          state_next = ST_RESP;
        end
      end

      // Check the free address and find its page.
      ST_FREE_CHECK: begin
        pend_addr_next = '0;
        if (free_bad) begin
          pend_status_next = STAT_BAD_ADDR;
          state_next       = ST_RESP;
        end else begin
          pend_status_next = STAT_OK;
          scan_idx_next    = NUM_W'(offset[ADDR_W-1:PAGE_SHIFT]);
          state_next       = ST_FREE_WALK;
        end
      end

      // Release pages until a last page, a free page or the heap end.
      ST_FREE_WALK: begin
        if (scan_idx < n_pages) begin
          rd_en         = 1'b1;
          rd_valid_next = 1'b1;
          rd_idx_next   = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + NUM_W'(1);
        end
        if (rd_valid) begin
          if (!rd_data.taken) begin
            rd_valid_next = 1'b0;
            state_next    = ST_RESP;
          end else begin
            wr.en   = 1'b1;
            wr.addr = rd_idx;
            if (rd_data.last || rd_is_final) begin
              rd_valid_next = 1'b0;
              state_next    = ST_RESP;
            end
          end
        end
      end

      // Hand the result to the output register once it is free.
      ST_RESP: begin
        if (!out_valid || !out_stall) begin
          out_valid_next      = 1'b1;
          result_address_next = pend_addr;
          status_next         = pend_status;
          state_next          = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
